FILE: sv/cobsd_pkg.sv
`default_nettype none
package cobsd_pkg;

  localparam int unsigned MaxFrameBytes = 4096;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 13;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CfgIdxW = 1;

  // Packed result data: data_byte, frame_length, zero fill to whole bytes
  localparam int unsigned OutDataW = 24;

  localparam logic [CountW-1:0] LimitCap = CountW'(MaxFrameBytes);
  localparam logic [CountW-1:0] MaxEncResetVal = CountW'(4096);

  localparam logic [ByteW-1:0] Delimiter = 8'h00;
  localparam logic [ByteW-1:0] MaxCode   = 8'hFF;

  typedef enum logic [KindW-1:0] {
    KIND_DATA      = 3'd0,
    KIND_OK        = 3'd1,
    KIND_MISMATCH  = 3'd2,
    KIND_TRUNCATED = 3'd3,
    KIND_OVERLONG  = 3'd4
  } kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_ENCODED_LENGTH = 1'b0,
    REG_EXPECTED_LENGTH    = 1'b1
  } cfg_reg_t;

endpackage
`default_nettype wire

FILE: sv/cobs_frame_decoder_core.sv
`default_nettype none
// An accepted input beat that yields a result has it registered in the output register.
// One input beat per cycle; input stalls only while a held result is not taken.
// Reset (rst_n low, synchronous): frame state cleared, output register emptied,
// max_encoded_length back to 4096 and expected_length back to 0.
module cobs_frame_decoder_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [cobsd_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [cobsd_pkg::CountW-1:0]  cfg_wdata,
  // received byte stream
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [cobsd_pkg::ByteW-1:0]   in_tdata,   // [7:0] rx_byte
  // decoded stream
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [cobsd_pkg::OutDataW-1:0]     out_tdata,  // [7:0] data_byte, [20:8] frame_length,
                                                         // [23:21] zero
  output logic [cobsd_pkg::KindW-1:0]        out_tuser   // [2:0] kind
);
  import cobsd_pkg::*;

  // configuration registers
  logic [CountW-1:0] max_enc_len_r;
  logic [CountW-1:0] exp_len_r;

  // frame state
  logic [CountW-1:0] enc_count_r, enc_count_nxt;
  logic [ByteW-1:0]  blk_rem_r, blk_rem_nxt;
  logic              zero_pend_r, zero_pend_nxt;
  logic [CountW-1:0] dec_count_r, dec_count_nxt;

  // output register
  logic              out_valid_r;
  kind_t             out_kind_r, res_kind;
  logic [ByteW-1:0]  out_data_r, res_data;
  logic [CountW-1:0] out_len_r, res_len;
  logic              res_valid;

  logic              accept;
  logic [CountW-1:0] limit;
  logic [CountW-1:0] dec_inc;

  // Take a new beat whenever the output register is empty or is being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Clamp the configured limit to the frame buffer size.
  assign limit   = (max_enc_len_r > LimitCap) ? LimitCap : max_enc_len_r;
  assign dec_inc = dec_count_r + CountW'(1);

  always_comb begin
    enc_count_nxt = enc_count_r;
    blk_rem_nxt   = blk_rem_r;
    zero_pend_nxt = zero_pend_r;
    dec_count_nxt = dec_count_r;
    res_valid     = 1'b0;
    res_kind      = KIND_DATA;
    res_data      = '0;
    res_len       = dec_count_r;

    if (in_tdata == Delimiter) begin
      // Delimiter: report the frame unless it was empty, then clear.
      if (enc_count_r != '0) begin
        res_valid = 1'b1;
        if (blk_rem_r != '0) begin
          res_kind = KIND_TRUNCATED;
        end else if (dec_count_r != exp_len_r) begin
          res_kind = KIND_MISMATCH;
        end else begin
          res_kind = KIND_OK;
        end
      end
      enc_count_nxt = '0;
      blk_rem_nxt   = '0;
      zero_pend_nxt = 1'b0;
      dec_count_nxt = '0;
    end else if (enc_count_r >= limit) begin
      // Overlong: drop this byte, report, resync on the next non-zero byte.
      res_valid     = 1'b1;
      res_kind      = KIND_OVERLONG;
      enc_count_nxt = '0;
      blk_rem_nxt   = '0;
      zero_pend_nxt = 1'b0;
      dec_count_nxt = '0;
    end else begin
      enc_count_nxt = enc_count_r + CountW'(1);
      if (blk_rem_r == '0) begin
        // Code byte: release the zero implied by the previous block, if any.
        zero_pend_nxt = (in_tdata != MaxCode);
        blk_rem_nxt   = in_tdata - ByteW'(1);
        if (zero_pend_r) begin
          res_valid     = 1'b1;
          dec_count_nxt = dec_inc;
          res_len       = dec_inc;
        end
      end else begin
        // Literal byte: pass it straight on.
        blk_rem_nxt   = blk_rem_r - ByteW'(1);
        dec_count_nxt = dec_inc;
        res_valid     = 1'b1;
        res_data      = in_tdata;
        res_len       = dec_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_enc_len_r <= MaxEncResetVal;
      exp_len_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_ENCODED_LENGTH: max_enc_len_r <= cfg_wdata;
        REG_EXPECTED_LENGTH:    exp_len_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_count_r <= '0;
      blk_rem_r   <= '0;
      zero_pend_r <= 1'b0;
      dec_count_r <= '0;
    end else if (accept) begin
      enc_count_r <= enc_count_nxt;
      blk_rem_r   <= blk_rem_nxt;
      zero_pend_r <= zero_pend_nxt;
      dec_count_r <= dec_count_nxt;
    end
  end

  // Output register: load on an accepted beat that yields a result, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_kind_r <= res_kind;
      out_data_r <= res_data;
      out_len_r  <= res_len;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OutDataW - ByteW - CountW)'(0), out_len_r, out_data_r};
  assign out_tuser  = out_kind_r;

endmodule
`default_nettype wire
